// ===== hdl/crle_pkg.sv =====
// Shared types and constants for the column RLE planar decoder.
// Used by the channel interfaces, the controller, the datapath and the top level.
package crle_pkg;

  // Field widths
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned ADDR_W     = 16;
  localparam int unsigned PLANE_W    = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;

  // Display page row stride in bytes
  localparam int unsigned ROW_STRIDE = 80;

  // Column type bytes and the repeat op threshold
  localparam logic [7:0] TYPE_PACKED  = 8'h80;
  localparam logic [7:0] TYPE_LITERAL = 8'h00;
  localparam logic [7:0] REP_MIN      = 8'd224;

  // Register reset values
  localparam logic [9:0] RST_COLUMN_TOTAL = 10'd320;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLUMN_TOTAL = 2'd0,
    REG_START_X      = 2'd1,
    REG_START_Y      = 2'd2
  } cfg_reg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic restart;   // reload frame position from the registers
    logic set_kind;  // latch column kind from the type byte
    logic load_pkt;  // packet byte count
    logic load_seq;  // sequence count
    logic delta;     // skip down rows, charge the packet count
    logic load_rep;  // start a repeat op
    logic load_val;  // latch the repeated value
    logic rep_dec;   // one repeat write done
    logic end_op;    // one data op done
    logic end_col;   // column finished
    logic result;    // load the output register
    logic write;     // result is a pixel write
    logic pix_rep;   // pixel from the repeat value
    logic last;      // final result of this byte
    logic done;      // frame finished
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_type;    // byte opens a packet column
    logic rep_op;     // byte is a repeat op in a packed column
    logic seq_last;   // sequence count runs out with this op
    logic pkt_zero;   // no packet bytes left
    logic cols_last;  // current column is the final one
    logic total_last; // a restarted frame has one column
    logic rep_last;   // final repeat write
    logic out_free;   // output register can take a beat
  } status_t;

endpackage

// ===== hdl/crle_byte_if.sv =====
// Input channel: one compressed stream byte per beat.
// Depends on crle_pkg.
interface crle_byte_if;
  logic                        valid;
  logic                        ready;
  logic [crle_pkg::BYTE_W-1:0] src_byte;
  logic                        frame_start;

  modport source (output valid, output src_byte, output frame_start, input ready);
  modport sink   (input valid, input src_byte, input frame_start, output ready);
endinterface

// ===== hdl/crle_pix_if.sv =====
// Output channel: one pixel write or status result per beat.
// Depends on crle_pkg.
interface crle_pix_if;
  logic                         valid;
  logic                         ready;
  logic                         write_enable;
  logic [crle_pkg::ADDR_W-1:0]  write_addr;
  logic [crle_pkg::PLANE_W-1:0] plane_mask;
  logic [crle_pkg::BYTE_W-1:0]  pixel;
  logic                         last;
  logic                         frame_done;

  modport source (output valid, output write_enable, output write_addr, output plane_mask,
                  output pixel, output last, output frame_done, input ready);
  modport sink   (input valid, input write_enable, input write_addr, input plane_mask,
                  input pixel, input last, input frame_done, output ready);
endinterface

// ===== hdl/column_rle_planar_decoder_unit.sv =====
// Column RLE decoder for four-plane VGA memory: top level.
// Depends on crle_pkg, crle_byte_if, crle_pix_if, crle_ctrl and crle_datapath.
//
// Takes one compressed byte per beat and returns one or more result beats per
// byte, the final one marked by last. Control bytes and literal data bytes give
// one beat each. A repeat op takes two bytes; the value byte is followed by 1
// to 32 write beats, one per cycle while the output register is free, during
// which no input is taken. The result beat goes through a single output
// register, so throughput is one byte per cycle outside repeat runs as long as
// the sink takes every beat; the output ready sets the pace otherwise. Writes
// to column_total and start_x apply at the next frame_start byte; start_y feeds
// the row base of every write directly and so applies from the next write on.
module column_rle_planar_decoder_unit (
  input  logic                            clk,
  input  logic                            rst,
  crle_byte_if.sink                       byte_in,
  crle_pix_if.source                      pix_out,
  input  logic                            cfg_write,
  input  logic [crle_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [crle_pkg::CFG_DATA_W-1:0] cfg_data
);
  import crle_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  assign byte_in.ready = in_ready;

  // Sequencer
  crle_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (byte_in.valid),
    .frame_start (byte_in.frame_start),
    .in_ready    (in_ready),
    .status      (status),
    .cmd         (cmd)
  );

  // Datapath and output register
  crle_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .src_byte     (byte_in.src_byte),
    .cmd          (cmd),
    .status       (status),
    .out_ready    (pix_out.ready),
    .out_valid    (pix_out.valid),
    .write_enable (pix_out.write_enable),
    .write_addr   (pix_out.write_addr),
    .plane_mask   (pix_out.plane_mask),
    .pixel        (pix_out.pixel),
    .last         (pix_out.last),
    .frame_done   (pix_out.frame_done)
  );

endmodule

// ===== hdl/crle_ctrl.sv =====
// Decode sequencer: tracks the stream phase and issues datapath commands.
// Depends on crle_pkg.
module crle_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              frame_start,
  output logic              in_ready,
  input  crle_pkg::status_t status,
  output crle_pkg::cmd_t    cmd
);
  import crle_pkg::*;

  typedef enum logic [7:0] {
    S_TYPE   = 8'b0000_0001,
    S_PKT    = 8'b0000_0010,
    S_SEQ    = 8'b0000_0100,
    S_DELTA  = 8'b0000_1000,
    S_DATA   = 8'b0001_0000,
    S_REPVAL = 8'b0010_0000,
    S_REPEAT = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;
  state_t cur;
  state_t eop_state;
  logic   accept;
  logic   eop_col;
  logic   eop_done;

  // Input is held off while repeat writes drain
  assign in_ready = status.out_free && (state != S_REPEAT);
  assign accept   = in_valid && in_ready;

  // A restart byte is always a column type byte
  assign cur = frame_start ? S_TYPE : state;

  // Where an op ends: more data, next packet, next column or frame end
  assign eop_col  = status.seq_last && status.pkt_zero;
  assign eop_done = eop_col && status.cols_last;
  always_comb begin
    if (!status.seq_last) begin
      eop_state = S_DATA;
    end else if (!status.pkt_zero) begin
      eop_state = S_SEQ;
    end else if (status.cols_last) begin
      eop_state = S_DONE;
    end else begin
      eop_state = S_TYPE;
    end
  end

  // Command decode
  always_comb begin
    state_next = state;
    cmd        = '0;
    if (accept) begin
      cmd.restart = frame_start;
      cmd.result  = 1'b1;
      cmd.last    = 1'b1;
      case (cur)
        S_TYPE: begin
          if (status.is_type) begin
            cmd.set_kind = 1'b1;
            state_next   = S_PKT;
          end else begin
            cmd.end_col = 1'b1;
            if (frame_start ? status.total_last : status.cols_last) begin
              cmd.done   = 1'b1;
              state_next = S_DONE;
            end else begin
              state_next = S_TYPE;
            end
          end
        end
        S_PKT: begin
          cmd.load_pkt = 1'b1;
          state_next   = S_SEQ;
        end
        S_SEQ: begin
          cmd.load_seq = 1'b1;
          state_next   = S_DELTA;
        end
        S_DELTA: begin
          cmd.delta  = 1'b1;
          state_next = S_DATA;
        end
        S_DATA: begin
          if (status.rep_op) begin
            cmd.load_rep = 1'b1;
            state_next   = S_REPVAL;
          end else begin
            cmd.write   = 1'b1;
            cmd.end_op  = 1'b1;
            cmd.end_col = eop_col;
            cmd.done    = eop_done;
            state_next  = eop_state;
          end
        end
        S_REPVAL: begin
          cmd.result   = 1'b0;
          cmd.last     = 1'b0;
          cmd.load_val = 1'b1;
          state_next   = S_REPEAT;
        end
        S_DONE: begin
          state_next = S_DONE;
        end
        default: begin
          state_next = S_DONE;
        end
      endcase
    end else if (state == S_REPEAT && status.out_free) begin
      // One repeat write per beat
      cmd.result  = 1'b1;
      cmd.write   = 1'b1;
      cmd.pix_rep = 1'b1;
      cmd.rep_dec = 1'b1;
      if (status.rep_last) begin
        cmd.last    = 1'b1;
        cmd.end_op  = 1'b1;
        cmd.end_col = eop_col;
        cmd.done    = eop_done;
        state_next  = eop_state;
      end
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_TYPE;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTH
  a_result_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.result |-> status.out_free)
    else $error("result issued while output register is full");

  a_repeat_ends_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_REPEAT && state_next != S_REPEAT) |-> (cmd.last && cmd.result))
    else $error("repeat run ended without a final beat");

  a_write_is_result: assert property (@(posedge clk) disable iff (rst)
    (cmd.write || cmd.done) |-> cmd.result)
    else $error("write or done flagged without a result");
`endif

endmodule

// ===== hdl/crle_datapath.sv =====
// Decoder datapath: config registers, column position, packet counters and
// the output register. Depends on crle_pkg.
module crle_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [crle_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [crle_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [crle_pkg::BYTE_W-1:0]    src_byte,
  input  crle_pkg::cmd_t                 cmd,
  output crle_pkg::status_t              status,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic                           write_enable,
  output logic [crle_pkg::ADDR_W-1:0]    write_addr,
  output logic [crle_pkg::PLANE_W-1:0]   plane_mask,
  output logic [crle_pkg::BYTE_W-1:0]    pixel,
  output logic                           last,
  output logic                           frame_done
);
  import crle_pkg::*;

  // Times the 80-byte row stride as two shifts and an add
  function automatic logic [15:0] times_stride(input logic [15:0] v);
    times_stride = (v << 6) + (v << 4);
  endfunction

  // Configuration registers
  logic [9:0]  column_total;
  logic [9:0]  start_x;
  logic [8:0]  start_y;

  // Decode state
  logic        column_kind;
  logic [9:0]  columns_left;
  logic [3:0]  cur_plane;
  logic [15:0] column_byte;
  logic [15:0] dest_offset;
  logic [7:0]  packet_left;
  logic [7:0]  sequence_left;
  logic [5:0]  repeat_count;
  logic [7:0]  rep_value;

  logic        column_kind_next;
  logic [9:0]  columns_left_next;
  logic [3:0]  cur_plane_next;
  logic [15:0] column_byte_next;
  logic [15:0] dest_offset_next;
  logic [7:0]  packet_left_next;
  logic [7:0]  sequence_left_next;
  logic [5:0]  repeat_count_next;
  logic [7:0]  rep_value_next;

  logic [3:0]  start_plane;
  logic [15:0] start_cbyte;
  logic [9:0]  cols_eff;
  logic [3:0]  plane_eff;
  logic [15:0] cbyte_eff;
  logic [15:0] row_base;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      column_total <= RST_COLUMN_TOTAL;
      start_x      <= '0;
      start_y      <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_COLUMN_TOTAL: column_total <= cfg_data;
        REG_START_X:      start_x      <= cfg_data;
        REG_START_Y:      start_y      <= cfg_data[8:0];
        default:          ;
      endcase
    end
  end

  // Frame origin and effective position on a restart
  assign start_plane = 4'b0001 << start_x[1:0];
  assign start_cbyte = {8'd0, start_x[9:2]};
  assign cols_eff    = cmd.restart ? column_total : columns_left;
  assign plane_eff   = cmd.restart ? start_plane  : cur_plane;
  assign cbyte_eff   = cmd.restart ? start_cbyte  : column_byte;
  assign row_base    = times_stride({7'd0, start_y});

  // Status to the controller
  assign status.is_type    = (src_byte == TYPE_PACKED) || (src_byte == TYPE_LITERAL);
  assign status.rep_op     = column_kind && (src_byte >= REP_MIN);
  assign status.seq_last   = (sequence_left == 8'd1);
  assign status.pkt_zero   = (packet_left == 8'd0);
  assign status.cols_last  = (columns_left == 10'd1);
  assign status.total_last = (column_total == 10'd1);
  assign status.rep_last   = (repeat_count == 6'd1);
  assign status.out_free   = !out_valid || out_ready;

  // Next decode state
  always_comb begin
    column_kind_next   = column_kind;
    columns_left_next  = columns_left;
    cur_plane_next     = cur_plane;
    column_byte_next   = column_byte;
    dest_offset_next   = dest_offset;
    packet_left_next   = packet_left;
    sequence_left_next = sequence_left;
    repeat_count_next  = repeat_count;
    rep_value_next     = rep_value;

    if (cmd.restart) begin
      columns_left_next = column_total;
      cur_plane_next    = start_plane;
      column_byte_next  = start_cbyte;
      dest_offset_next  = start_cbyte;
    end
    if (cmd.set_kind) begin
      column_kind_next = (src_byte == TYPE_PACKED);
    end
    if (cmd.load_pkt) begin
      packet_left_next = src_byte;
    end
    if (cmd.load_seq) begin
      sequence_left_next = src_byte;
    end
    if (cmd.delta) begin
      dest_offset_next = dest_offset + times_stride({8'd0, src_byte});
      packet_left_next = packet_left - (sequence_left + 8'd2);
    end
    if (cmd.load_rep) begin
      // op 224..255 gives 1..32 writes
      repeat_count_next  = {1'b0, src_byte[4:0]} + 6'd1;
      sequence_left_next = sequence_left - 8'd1;
    end
    if (cmd.load_val) begin
      rep_value_next = src_byte;
    end
    if (cmd.rep_dec) begin
      repeat_count_next = repeat_count - 6'd1;
    end
    if (cmd.write) begin
      dest_offset_next = dest_offset + 16'(ROW_STRIDE);
    end
    if (cmd.end_op) begin
      sequence_left_next = sequence_left - 8'd1;
    end
    // Column end: count down, step plane, wrap plane 8 into the next byte
    if (cmd.end_col) begin
      columns_left_next = cols_eff - 10'd1;
      if (cols_eff != 10'd1) begin
        if (plane_eff[3]) begin
          cur_plane_next   = 4'b0001;
          column_byte_next = cbyte_eff + 16'd1;
          dest_offset_next = cbyte_eff + 16'd1;
        end else begin
          cur_plane_next   = plane_eff << 1;
          column_byte_next = cbyte_eff;
          dest_offset_next = cbyte_eff;
        end
      end
    end
  end

  // Decode state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      column_kind   <= 1'b0;
      columns_left  <= RST_COLUMN_TOTAL;
      cur_plane     <= 4'b0001;
      column_byte   <= '0;
      dest_offset   <= '0;
      packet_left   <= '0;
      sequence_left <= '0;
      repeat_count  <= '0;
    end else begin
      column_kind   <= column_kind_next;
      columns_left  <= columns_left_next;
      cur_plane     <= cur_plane_next;
      column_byte   <= column_byte_next;
      dest_offset   <= dest_offset_next;
      packet_left   <= packet_left_next;
      sequence_left <= sequence_left_next;
      repeat_count  <= repeat_count_next;
    end
  end

  always_ff @(posedge clk) begin
    rep_value <= rep_value_next;
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload; non-write beats carry zeros
  always_ff @(posedge clk) begin
    if (cmd.result) begin
      write_enable <= cmd.write;
      last         <= cmd.last;
      frame_done   <= cmd.done;
      if (cmd.write) begin
        write_addr <= row_base + dest_offset;
        plane_mask <= cur_plane;
        pixel      <= cmd.pix_rep ? rep_value : src_byte;
      end else begin
        write_addr <= '0;
        plane_mask <= '0;
        pixel      <= '0;
      end
    end
  end

`ifndef SYNTH
  a_plane_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(cur_plane))
    else $error("plane select is not one-hot");

  a_repeat_range: assert property (@(posedge clk) disable iff (rst)
    repeat_count <= 6'd32)
    else $error("repeat count out of range");

  a_blank_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !write_enable) |-> (write_addr == '0 && plane_mask == '0 && pixel == '0))
    else $error("non-write beat carries a payload");
`endif

endmodule

// ===== dv/column_rle_planar_decoder_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for column_rle_planar_decoder_unit.
// Depends on crle_pkg, crle_byte_if, crle_pix_if and the decoder RTL. A built-in column
// decoder model predicts every result beat, and random valid/ready gaps pace both channels.
module column_rle_planar_decoder_unit_tb;
  import crle_pkg::*;

  localparam int ROW_BYTES = 80;
  localparam logic [7:0] TYPE_EMPTY = 8'hFF;
  localparam int QUIET_LIMIT = 1000;
  localparam int TAIL_CYCLES = 40;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_BYTES = 40;

  typedef enum logic [2:0] {
    DS_TYPE, DS_PKT, DS_SEQ, DS_DELTA, DS_DATA, DS_REPVAL, DS_DONE
  } dec_state_t;

  typedef struct packed {
    logic [7:0] data;
    logic       fs;
  } src_beat_t;

  typedef struct packed {
    logic        we;
    logic [15:0] addr;
    logic [3:0]  mask;
    logic [7:0]  pixel;
    logic        last;
    logic        done;
  } pix_beat_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  crle_byte_if byte_if ();
  crle_pix_if  pix_if ();

  column_rle_planar_decoder_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .byte_in   (byte_if),
    .pix_out   (pix_if),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // Stream bytes waiting for the driver, results waiting for the checker
  src_beat_t stream_q[$];
  pix_beat_t expected_pix[$];
  pix_beat_t step_beats[$];

  // Register copies and decoder state of the model
  logic [9:0]  m_total, m_x;
  logic [8:0]  m_y;
  dec_state_t  dec_st;
  logic        col_packed;
  logic [9:0]  cols_left;
  logic [3:0]  plane;
  logic [15:0] col_byte, dest;
  logic [7:0]  pkt_left, seq_left;
  logic [5:0]  rep_cnt;

  bit in_fire, out_fire;
  bit src_idle_on, sink_idle_on;
  int src_gap, sink_stall, quiet;
  int unsigned fails, n_bytes, n_writes, n_frames, n_settings, stim_count;

  // ---------------------------------------------------------------- model
  task automatic reload_frame();
    dec_st     = DS_TYPE;
    col_packed = 1'b0;
    cols_left  = m_total;
    plane      = 4'b0001 << m_x[1:0];
    col_byte   = {8'h00, m_x[9:2]};
    dest       = col_byte;
    pkt_left   = '0;
    seq_left   = '0;
    rep_cnt    = '0;
  endtask

  task automatic emit_write(input logic [7:0] pix);
    pix_beat_t w;
    w.we    = 1'b1;
    w.addr  = 16'(int'(m_y) * ROW_BYTES + int'(dest));
    w.mask  = plane;
    w.pixel = pix;
    w.last  = 1'b0;
    w.done  = 1'b0;
    dest = dest + 16'(ROW_BYTES);
    step_beats.push_back(w);
  endtask

  // Returns 1 when the frame's final column just closed
  function automatic logic close_column();
    cols_left = cols_left - 10'd1;
    if (cols_left == 10'd0) begin
      dec_st = DS_DONE;
      return 1'b1;
    end
    if (plane == 4'b1000) begin
      plane    = 4'b0001;
      col_byte = col_byte + 16'd1;
    end else begin
      plane = plane << 1;
    end
    dest   = col_byte;
    dec_st = DS_TYPE;
    return 1'b0;
  endfunction

  function automatic logic close_op();
    seq_left = seq_left - 8'd1;
    if (seq_left != 8'd0) begin
      dec_st = DS_DATA;
      return 1'b0;
    end
    if (pkt_left != 8'd0) begin
      dec_st = DS_SEQ;
      return 1'b0;
    end
    return close_column();
  endfunction

  // Works out every result beat that one stream byte causes
  task automatic decode_byte(input logic [7:0] b, input logic fs);
    logic done;
    pix_beat_t z;
    int i;
    done = 1'b0;
    step_beats.delete();
    if (fs) reload_frame();
    case (dec_st)
      DS_TYPE: begin
        if (b == TYPE_PACKED || b == TYPE_LITERAL) begin
          col_packed = (b == TYPE_PACKED);
          dec_st = DS_PKT;
        end else begin
          done = close_column();
        end
      end
      DS_PKT: begin
        pkt_left = b;
        dec_st = DS_SEQ;
      end
      DS_SEQ: begin
        seq_left = b;
        dec_st = DS_DELTA;
      end
      DS_DELTA: begin
        dest = dest + 16'(ROW_BYTES * int'(b));
        pkt_left = pkt_left - seq_left - 8'd2;
        dec_st = DS_DATA;
      end
      DS_DATA: begin
        if (col_packed && b >= REP_MIN) begin
          rep_cnt = 6'(int'(b) - int'(REP_MIN) + 1);
          seq_left = seq_left - 8'd1;
          dec_st = DS_REPVAL;
        end else begin
          emit_write(b);
          done = close_op();
        end
      end
      DS_REPVAL: begin
        for (i = 0; i < int'(rep_cnt) && i < 32; i++) emit_write(b);
        rep_cnt = '0;
        done = close_op();
      end
      default: dec_st = DS_DONE;
    endcase
    // a byte with no pixel still answers with one empty beat
    if (step_beats.size() == 0) begin
      z = '0;
      step_beats.push_back(z);
    end
    step_beats[step_beats.size()-1].last = 1'b1;
    step_beats[step_beats.size()-1].done = done;
    foreach (step_beats[k]) expected_pix.push_back(step_beats[k]);
  endtask

  // ---------------------------------------------------------------- stimulus
  task automatic put(input logic [7:0] b, input logic fs);
    stream_q.push_back('{data: b, fs: fs});
    stim_count++;
  endtask

  task automatic add_packet_column(input logic [7:0] typ, input logic fs);
    logic [7:0] body[$];
    logic [7:0] ops[$];
    logic [7:0] pkt_bytes;
    int npk, nops, units, p, k;
    pkt_bytes = '0;
    npk = $urandom_range(1, 3);
    for (p = 0; p < npk; p++) begin
      ops.delete();
      units = 0;
      nops = $urandom_range(1, 5);
      for (k = 0; k < nops; k++) begin
        if (typ == TYPE_PACKED && $urandom_range(0, 2) == 0) begin
          // repeat op and its value, mostly short runs
          if ($urandom_range(0, 3) == 0) ops.push_back(8'($urandom_range(224, 255)));
          else ops.push_back(8'($urandom_range(224, 227)));
          ops.push_back(8'($urandom));
          units += 2;
        end else begin
          if (typ == TYPE_PACKED) ops.push_back(8'($urandom_range(0, 223)));
          else if ($urandom_range(0, 1) == 0) ops.push_back(8'($urandom_range(224, 255)));
          else ops.push_back(8'($urandom));
          units += 1;
        end
      end
      body.push_back(8'(units));
      if ($urandom_range(0, 7) == 0) body.push_back(8'($urandom));
      else body.push_back(8'($urandom_range(0, 3)));
      foreach (ops[j]) body.push_back(ops[j]);
      pkt_bytes = pkt_bytes + 8'(units + 2);
    end
    put(typ, fs);
    put(pkt_bytes, 1'b0);
    foreach (body[j]) put(body[j], 1'b0);
  endtask

  task automatic add_column(input logic fs);
    int r;
    logic [7:0] t;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      put(TYPE_EMPTY, fs);
    end else if (r < 25) begin
      do t = 8'($urandom_range(1, 254)); while (t == TYPE_PACKED);
      put(t, fs);
    end else if (r < 75) begin
      add_packet_column(TYPE_PACKED, fs);
    end else begin
      add_packet_column(TYPE_LITERAL, fs);
    end
  endtask

  // Well-formed frame; complete when the column total is small
  task automatic add_frame();
    int ncol, c, n;
    bit whole;
    whole = (m_total >= 10'd1 && m_total <= 10'd6);
    ncol = whole ? int'(m_total) : $urandom_range(1, 4);
    for (c = 0; c < ncol; c++) add_column(c == 0);
    // trailing bytes after frame done are ignored, not counted
    if (whole && $urandom_range(0, 2) == 0) begin
      n = $urandom_range(1, 2);
      repeat (n) stream_q.push_back('{data: 8'($urandom), fs: 1'b0});
    end
  endtask

  task automatic add_broken();
    int n;
    case ($urandom_range(0, 2))
      0: begin
        // zero sequence count, abandoned by the next restart
        put(TYPE_PACKED, 1'b1);
        put(8'($urandom), 1'b0);
        put(8'd0, 1'b0);
        put(8'($urandom_range(0, 3)), 1'b0);
        n = $urandom_range(3, 8);
        repeat (n) put(8'($urandom_range(0, 223)), 1'b0);
      end
      1: begin
        // repeat op on the last sequence count, counter wraps
        put(TYPE_PACKED, 1'b1);
        put(8'($urandom), 1'b0);
        put(8'd1, 1'b0);
        put(8'd0, 1'b0);
        put(8'($urandom_range(224, 255)), 1'b0);
        put(8'($urandom), 1'b0);
        n = $urandom_range(2, 4);
        repeat (n) put(8'($urandom_range(0, 223)), 1'b0);
      end
      default: begin
        n = $urandom_range(3, 8);
        repeat (n) put(8'($urandom), 1'($urandom_range(0, 3) == 0));
      end
    endcase
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [9:0] val);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    case (idx)
      REG_COLUMN_TOTAL: m_total = val;
      REG_START_X:      m_x = val;
      REG_START_Y:      m_y = val[8:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // Checked just after the falling edge, once the driver has settled
  task automatic wait_drained();
    do begin
      @(negedge clk);
      #1;
    end while (stream_q.size() != 0 || byte_if.valid || expected_pix.size() != 0);
  endtask

  // ---------------------------------------------------------------- driver
  always @(negedge clk) begin
    src_beat_t nxt;
    if (rst) begin
      src_gap = 0;
      byte_if.valid <= 1'b0;
    end else if (!byte_if.valid || in_fire) begin
      if (in_fire) src_gap = src_idle_on ? $urandom_range(0, 16) : 0;
      if (src_gap == 0 && stream_q.size() != 0) begin
        nxt = stream_q.pop_front();
        byte_if.valid       <= 1'b1;
        byte_if.src_byte    <= nxt.data;
        byte_if.frame_start <= nxt.fs;
      end else begin
        if (src_gap != 0) src_gap--;
        byte_if.valid <= 1'b0;
      end
    end
  end

  // Result sink: random stall after each beat
  always @(negedge clk) begin
    if (rst) begin
      sink_stall = 0;
      pix_if.ready <= 1'b0;
    end else begin
      if (out_fire) sink_stall = sink_idle_on ? $urandom_range(0, 16) : 0;
      else if (sink_stall != 0) sink_stall--;
      pix_if.ready <= (sink_stall == 0);
    end
  end

  // ---------------------------------------------------------------- monitor
  task automatic check_beat();
    pix_beat_t want;
    if (expected_pix.size() == 0) begin
      $error("unexpected result beat: we=%0d addr=%h mask=%h pixel=%h",
             pix_if.write_enable, pix_if.write_addr, pix_if.plane_mask, pix_if.pixel);
      fails++;
    end else begin
      want = expected_pix.pop_front();
      if (pix_if.write_enable !== want.we) begin
        $error("write_enable: expected %0d, got %0d", want.we, pix_if.write_enable);
        fails++;
      end
      if (pix_if.write_addr !== want.addr) begin
        $error("write_addr: expected %h, got %h", want.addr, pix_if.write_addr);
        fails++;
      end
      if (pix_if.plane_mask !== want.mask) begin
        $error("plane_mask: expected %h, got %h", want.mask, pix_if.plane_mask);
        fails++;
      end
      if (pix_if.pixel !== want.pixel) begin
        $error("pixel: expected %h, got %h", want.pixel, pix_if.pixel);
        fails++;
      end
      if (pix_if.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, pix_if.last);
        fails++;
      end
      if (pix_if.frame_done !== want.done) begin
        $error("frame_done: expected %0d, got %0d", want.done, pix_if.frame_done);
        fails++;
      end
    end
    if (pix_if.write_enable === 1'b1) n_writes++;
    if (pix_if.frame_done === 1'b1) n_frames++;
  endtask

  // Predict on the input beat first, then check any result beat of this edge
  always @(posedge clk) begin
    in_fire  = !rst && byte_if.valid && byte_if.ready;
    out_fire = !rst && pix_if.valid && pix_if.ready;
    if (in_fire) begin
      decode_byte(byte_if.src_byte, byte_if.frame_start);
      n_bytes++;
    end
    if (out_fire) check_beat();
    // watchdog on beat activity
    if (rst || in_fire || out_fire) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("no beat moved for %0d cycles", QUIET_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    int target, ph;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_COLUMN_TOTAL;
    cfg_data = '0;
    byte_if.valid = 1'b0;
    byte_if.src_byte = '0;
    byte_if.frame_start = 1'b0;
    pix_if.ready = 1'b0;
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    fails = 0; n_bytes = 0; n_writes = 0; n_frames = 0; stim_count = 0;
    n_settings = 1;
    quiet = 0;
    m_total = RST_COLUMN_TOTAL;
    m_x = '0;
    m_y = '0;
    reload_frame();
    dest = '0;

    repeat (3) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Reset settings, no idling: every column type, literal extremes,
    // shortest repeat, and bytes of 224 and up taken as literals
    put(TYPE_EMPTY, 1'b0);
    put(8'h01, 1'b0);
    put(TYPE_PACKED, 1'b0);
    put(8'd6, 1'b0);
    put(8'd4, 1'b0);
    put(8'd0, 1'b0);
    put(8'h00, 1'b0);
    put(REP_MIN - 8'd1, 1'b0);
    put(REP_MIN, 1'b0);
    put(8'hFF, 1'b0);
    put(TYPE_LITERAL, 1'b0);
    put(8'd3, 1'b0);
    put(8'd1, 1'b0);
    put(8'd2, 1'b0);
    put(8'hE5, 1'b0);
    wait_drained();

    // One column at the far corner: longest repeat, full skips so the
    // offset wraps, frame done, then an ignored byte
    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;
    write_reg(REG_COLUMN_TOTAL, 10'd1);
    write_reg(REG_START_X, 10'd1023);
    write_reg(REG_START_Y, 10'd511);
    n_settings++;
    put(TYPE_PACKED, 1'b1);
    put(8'd7, 1'b0);
    put(8'd2, 1'b0);
    put(8'd255, 1'b0);
    put(REP_MIN + 8'd31, 1'b0);
    put(8'hAA, 1'b0);
    put(8'd1, 1'b0);
    put(8'd255, 1'b0);
    put(8'h55, 1'b0);
    stream_q.push_back('{data: 8'h13, fs: 1'b0});
    wait_drained();

    // Random phases, each under its own register setting and pacing
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      src_idle_on = ($urandom_range(0, 3) != 0);
      sink_idle_on = ($urandom_range(0, 3) != 0);
      if (ph == 0) begin
        write_reg(REG_COLUMN_TOTAL, 10'd1023);
        write_reg(REG_START_X, 10'd0);
        write_reg(REG_START_Y, 10'd0);
      end else if (ph == 1) begin
        // zero total wraps to 1024 columns
        write_reg(REG_COLUMN_TOTAL, 10'd0);
        write_reg(REG_START_X, 10'd3);
      end else begin
        if ($urandom_range(0, 3) != 0) write_reg(REG_COLUMN_TOTAL, 10'($urandom_range(1, 6)));
        else write_reg(REG_COLUMN_TOTAL, 10'($urandom));
        if ($urandom_range(0, 2) != 0) write_reg(REG_START_X, 10'($urandom));
        if ($urandom_range(0, 2) != 0) write_reg(REG_START_Y, 10'($urandom_range(0, 511)));
      end
      n_settings++;
      target = stim_count + PHASE_BYTES;
      // open with a restart so new registers apply
      add_frame();
      while (stim_count < target) begin
        if ($urandom_range(0, 4) == 0) add_broken();
        else add_frame();
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(negedge clk);
    if (expected_pix.size() != 0) begin
      $error("%0d expected result beats never arrived", expected_pix.size());
      fails += expected_pix.size();
    end
    $display("Decoded %0d stream bytes under %0d register settings", n_bytes, n_settings);
    $display("Saw %0d pixel writes and %0d finished frames", n_writes, n_frames);
    if (fails == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
